[rtl/core/mfpq_pkg.sv]
// ----------------------------------------------------------------------------
// mfpq_pkg
// Types, codes and helpers shared by the multi-level FIFO priority queue.
// ----------------------------------------------------------------------------
package mfpq_pkg;

   localparam int LEVELS_DEF     = 9;
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int MODE_W    = 2;
   localparam int LEVEL_W   = 4;
   localparam int AGE_W     = 7;
   localparam int ENTRY_W   = 32;
   localparam int TOTAL_W   = 8;
   localparam int STATUS_W  = 2;
   localparam int SCAN_W    = 16;
   localparam int BANDS     = 8;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   localparam logic [AGE_W-1:0] BAND_TOP [BANDS] =
      '{7'd9, 7'd19, 7'd29, 7'd39, 7'd49, 7'd59, 7'd69, 7'd79};

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT     = 2'd0,
      MODE_INSERT_AGE = 2'd1,
      MODE_REMOVE     = 2'd2,
      MODE_QUERY      = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_DROP  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [LEVEL_W-1:0]  head_level;
      logic                is_empty;
      logic [TOTAL_W-1:0]  total_count;
   } meta_type;

   function automatic logic [LEVEL_W-1:0] age_to_level(input logic [AGE_W-1:0] age);
      logic [LEVEL_W-1:0] lv;
      lv = LEVEL_W'(BANDS);
      for (int k = BANDS - 1; k >= 0; k--) begin
         if (age <= BAND_TOP[k]) begin
            lv = LEVEL_W'(k);
         end
      end
      return lv;
   endfunction

   function automatic logic [LEVEL_W-1:0] first_set(input logic [SCAN_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = '0;
      for (int k = SCAN_W - 1; k >= 0; k--) begin
         if (v[k]) begin
            r = LEVEL_W'(k);
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/mfpq_ram.sv]
// ----------------------------------------------------------------------------
// mfpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 144
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mfpq_core.sv]
// ----------------------------------------------------------------------------
// mfpq_core
// Per-level head pointers and fill counts, operation decode, store write
// and lookup of the new head address.
// ----------------------------------------------------------------------------
module mfpq_core #(
   parameter int LEVELS     = mfpq_pkg::LEVELS_DEF,
   parameter int DEPTH      = mfpq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = mfpq_pkg::DATA_WIDTH_DEF,
   localparam int ADDR_W    = $clog2(LEVELS * DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [mfpq_pkg::MODE_W-1:0]       mode,
   input  logic [mfpq_pkg::LEVEL_W-1:0]      level,
   input  logic [mfpq_pkg::AGE_W-1:0]        age,
   input  logic [DATA_WIDTH-1:0]             data,
   output logic                              wr_en,
   output logic [ADDR_W-1:0]                 wr_addr,
   output logic [DATA_WIDTH-1:0]             wr_data,
   output logic [ADDR_W-1:0]                 rd_addr,
   output mfpq_pkg::meta_type                meta
);

   localparam int LVL_W = $clog2(LEVELS);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [PTR_W-1:0]                   head_ff  [LEVELS];
   logic [PTR_W-1:0]                   head_in  [LEVELS];
   logic [CNT_W-1:0]                   cnt_ff   [LEVELS];
   logic [CNT_W-1:0]                   cnt_in   [LEVELS];
   logic [mfpq_pkg::TOTAL_W-1:0]       total_ff;
   logic [mfpq_pkg::TOTAL_W-1:0]       total_in;

   mfpq_pkg::mode_type                 op;
   logic [mfpq_pkg::LEVEL_W-1:0]       age_lvl;
   logic [LVL_W-1:0]                   tgt;
   logic                               lvl_ok;
   logic                               ins_op;
   logic                               ins_ok;
   logic                               rem_ok;
   logic [SUM_W-1:0]                   pos_sum;
   logic [SUM_W-1:0]                   pos_wrap;
   logic [LEVELS-1:0]                  ne_cur;
   logic [LEVELS-1:0]                  ne_next;
   logic [LVL_W-1:0]                   hc;
   logic [LVL_W-1:0]                   hn;
   logic                               any_cur;
   logic                               any_next;
   mfpq_pkg::status_type               status;

   assign op      = mfpq_pkg::mode_type'(mode);
   assign age_lvl = mfpq_pkg::age_to_level(age);

   always_comb begin
      lvl_ok = 1'b1;
      ins_op = 1'b0;
      tgt    = '0;
      unique case (op)
         mfpq_pkg::MODE_INSERT: begin
            ins_op = 1'b1;
            lvl_ok = int'(level) < LEVELS;
            tgt    = lvl_ok ? level[LVL_W-1:0] : '0;
         end
         mfpq_pkg::MODE_INSERT_AGE: begin
            ins_op = 1'b1;
            tgt    = (int'(age_lvl) > LEVELS - 1) ? LVL_W'(LEVELS - 1)
                                                   : age_lvl[LVL_W-1:0];
         end
         mfpq_pkg::MODE_REMOVE: begin
         end
         mfpq_pkg::MODE_QUERY: begin
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < LEVELS; k++) begin
         ne_cur[k] = cnt_ff[k] != '0;
      end
   end

   assign hc      = LVL_W'(mfpq_pkg::first_set(mfpq_pkg::SCAN_W'(ne_cur)));
   assign any_cur = |ne_cur;
   assign ins_ok  = ins_op && lvl_ok && (cnt_ff[tgt] != CNT_W'(DEPTH));
   assign rem_ok  = (op == mfpq_pkg::MODE_REMOVE) && any_cur;

   assign pos_sum  = SUM_W'(head_ff[tgt]) + SUM_W'(cnt_ff[tgt]);
   assign pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? pos_sum - SUM_W'(DEPTH) : pos_sum;

   always_comb begin
      for (int k = 0; k < LEVELS; k++) begin
         head_in[k] = head_ff[k];
         cnt_in[k]  = cnt_ff[k];
      end
      total_in = total_ff;
      if (ins_ok) begin
         cnt_in[tgt] = cnt_ff[tgt] + CNT_W'(1);
         total_in    = total_ff + mfpq_pkg::TOTAL_W'(1);
      end
      if (rem_ok) begin
         cnt_in[hc]  = cnt_ff[hc] - CNT_W'(1);
         head_in[hc] = (head_ff[hc] == PTR_W'(DEPTH - 1)) ? '0
                                                          : head_ff[hc] + PTR_W'(1);
         total_in    = total_ff - mfpq_pkg::TOTAL_W'(1);
      end
   end

   always_comb begin
      for (int k = 0; k < LEVELS; k++) begin
         ne_next[k] = cnt_in[k] != '0;
      end
   end

   assign hn       = LVL_W'(mfpq_pkg::first_set(mfpq_pkg::SCAN_W'(ne_next)));
   assign any_next = |ne_next;

   always_comb begin
      status = mfpq_pkg::STAT_OK;
      if (ins_op && !ins_ok) begin
         status = mfpq_pkg::STAT_DROP;
      end else if (op == mfpq_pkg::MODE_REMOVE && !any_cur) begin
         status = mfpq_pkg::STAT_EMPTY;
      end
   end

   assign wr_en   = fire && ins_ok;
   assign wr_addr = ADDR_W'(tgt) * ADDR_W'(DEPTH) + ADDR_W'(pos_wrap[PTR_W-1:0]);
   assign wr_data = data;
   assign rd_addr = ADDR_W'(hn) * ADDR_W'(DEPTH) + ADDR_W'(head_in[hn]);

   assign meta.status      = status;
   assign meta.head_level  = any_next ? mfpq_pkg::LEVEL_W'(hn) : '0;
   assign meta.is_empty    = !any_next;
   assign meta.total_count = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LEVELS; k++) begin
            head_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
         total_ff <= '0;
      end else if (fire) begin
         for (int k = 0; k < LEVELS; k++) begin
            head_ff[k] <= head_in[k];
            cnt_ff[k]  <= cnt_in[k];
         end
         total_ff <= total_in;
      end
   end

endmodule

[rtl/core/multilevel_fifo_priority_queue.sv]
// ----------------------------------------------------------------------------
// multilevel_fifo_priority_queue
// Priority queue with one circular FIFO per level; level 0 is served first,
// oldest first within a level. Each item inserts, removes or queries and
// yields one item with the head entry, its level, count and status.
// ----------------------------------------------------------------------------
//  channel   dir   tdata (low bit up)                                  tuser
//  req_      in    level[3:0] age[10:4] entry_data[42:11]              mode
//  rsp_      out   head_data[31:0] head_level[35:32] is_empty[36]      -
//                  total_count[44:37] status[46:45]
//
//  One item per cycle while results are taken; an accepted item is held in
//  the input register, then processed into the result register and offered.
//  The store takes one write and one head read per cycle.
//  Reset clears head pointers, fill counts and the total; the store is not
//  cleared, since the head entry of an empty queue is shown as zero.
//  A stalled result holds the result register; the input register still
//  takes one more item behind it.
// ----------------------------------------------------------------------------
module multilevel_fifo_priority_queue #(
   parameter int LEVELS     = mfpq_pkg::LEVELS_DEF,
   parameter int DEPTH      = mfpq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = mfpq_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // level, age, entry_data
   input  logic [mfpq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode
   input  logic [mfpq_pkg::MODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // head_data, head_level, is_empty, total_count, status
   output logic [mfpq_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int ADDR_W = $clog2(LEVELS * DEPTH);

   logic                              in_vld_ff;
   logic                              in_vld_in;
   logic [mfpq_pkg::MODE_W-1:0]       mode_ff;
   logic [mfpq_pkg::LEVEL_W-1:0]      level_ff;
   logic [mfpq_pkg::AGE_W-1:0]        age_ff;
   logic [DATA_WIDTH-1:0]             data_ff;
   logic                              out_vld_ff;
   logic                              out_vld_in;
   mfpq_pkg::meta_type                meta_ff;
   mfpq_pkg::meta_type                meta;
   logic                              fwd_ff;
   logic [DATA_WIDTH-1:0]             fwd_data_ff;

   logic                              advance;
   logic                              req_take;
   logic                              wr_en;
   logic [ADDR_W-1:0]                 wr_addr;
   logic [DATA_WIDTH-1:0]             wr_data;
   logic [ADDR_W-1:0]                 rd_addr;
   logic [DATA_WIDTH-1:0]             rd_data;
   logic [DATA_WIDTH-1:0]             head_raw;
   logic [mfpq_pkg::ENTRY_W-1:0]      head_data;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !reset && (!in_vld_ff || advance);
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   mfpq_core #(
      .LEVELS     (LEVELS),
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .mode    (mode_ff),
      .level   (level_ff),
      .age     (age_ff),
      .data    (data_ff),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .meta    (meta)
   );

   mfpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (LEVELS * DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_ff <= req_tdata[3:0];
         age_ff   <= req_tdata[10:4];
         data_ff  <= DATA_WIDTH'(req_tdata[42:11]);
         mode_ff  <= req_tuser;
      end
      if (advance) begin
         meta_ff     <= meta;
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign head_raw  = meta_ff.is_empty ? '0 : (fwd_ff ? fwd_data_ff : rd_data);
   assign head_data = mfpq_pkg::ENTRY_W'(head_raw);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, meta_ff.status, meta_ff.total_count, meta_ff.is_empty,
                        meta_ff.head_level, head_data};

`ifndef SYNTH
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(meta_ff))
      else $error("result changed while stalled");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("processed item produced no result");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && meta_ff.is_empty |-> meta_ff.total_count == '0)
      else $error("empty queue with nonzero count");

   a_remove_empty: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && meta_ff.status == mfpq_pkg::STAT_EMPTY |-> meta_ff.is_empty)
      else $error("remove flagged empty on a nonempty queue");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && meta_ff.is_empty |-> meta_ff.head_level == '0 && head_data == '0)
      else $error("empty queue reports a head entry");
`endif

endmodule

[tb/sv/mfpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpq_checker
// Watches both streams of the priority queue and keeps a model of the nine
// level FIFOs. It works out the expected head report for each accepted
// request, then compares each result item field by field with the oldest
// expected report.
// ----------------------------------------------------------------------------
module mfpq_checker
   import mfpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,
   input  logic [MODE_W-1:0]        req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_TDATA_W-1:0]   rsp_tdata,
   output int                       error_count,
   output int                       pending,
   output int                       n_requests,
   output int                       n_results,
   output int                       n_full_drops,
   output int                       n_range_drops,
   output int                       n_empty_removes,
   output int                       peak_total
);

   localparam int NLEV    = LEVELS_DEF;
   localparam int NSLOT   = DEPTH_DEF;
   localparam int OLD_AGE = BANDS * 10;

   typedef struct packed {
      logic [ENTRY_W-1:0] head_data;
      logic [LEVEL_W-1:0] head_level;
      logic               is_empty;
      logic [TOTAL_W-1:0] total_count;
      status_type         status;
   } head_report_type;

   logic [ENTRY_W-1:0] slot_mem [NLEV][NSLOT];
   int                 rd_ptr   [NLEV];
   int                 fill_cnt [NLEV];
   head_report_type    owed_reports [$];

   int mismatches    = 0;
   int cnt_requests  = 0;
   int cnt_results   = 0;
   int cnt_full      = 0;
   int cnt_range     = 0;
   int cnt_empty     = 0;
   int cnt_peak      = 0;

   function automatic int first_busy();
      for (int k = 0; k < NLEV; k++) begin
         if (fill_cnt[k] != 0) return k;
      end
      return -1;
   endfunction

   function automatic head_report_type apply_request(input mode_type op,
                                                     input logic [LEVEL_W-1:0] lv_in,
                                                     input logic [AGE_W-1:0] age,
                                                     input logic [ENTRY_W-1:0] payload);
      head_report_type r;
      int lv;
      int top;
      int total;
      r = '0;
      r.status = STAT_OK;
      lv = 0;
      case (op)
         MODE_INSERT: lv = int'(lv_in);
         MODE_INSERT_AGE: begin
            lv = (int'(age) >= OLD_AGE) ? BANDS : int'(age) / 10;
            if (lv > NLEV - 1) lv = NLEV - 1;
         end
         MODE_REMOVE: begin
            top = first_busy();
            if (top < 0) begin
               r.status = STAT_EMPTY;
               cnt_empty++;
            end else begin
               rd_ptr[top] = (rd_ptr[top] + 1) % NSLOT;
               fill_cnt[top]--;
            end
         end
         default: ;
      endcase
      if (op == MODE_INSERT || op == MODE_INSERT_AGE) begin
         if (lv >= NLEV) begin
            r.status = STAT_DROP;
            cnt_range++;
         end else if (fill_cnt[lv] >= NSLOT) begin
            r.status = STAT_DROP;
            cnt_full++;
         end else begin
            slot_mem[lv][(rd_ptr[lv] + fill_cnt[lv]) % NSLOT] = payload;
            fill_cnt[lv]++;
         end
      end
      total = 0;
      for (int k = 0; k < NLEV; k++) total += fill_cnt[k];
      if (total > cnt_peak) cnt_peak = total;
      r.total_count = TOTAL_W'(total);
      top = first_busy();
      if (top < 0) begin
         r.is_empty = 1'b1;
      end else begin
         r.head_data  = slot_mem[top][rd_ptr[top]];
         r.head_level = LEVEL_W'(top);
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [ENTRY_W-1:0] want,
                              input logic [ENTRY_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      head_report_type want;
      head_report_type got;
      if (reset) begin
         for (int k = 0; k < NLEV; k++) begin
            rd_ptr[k]   = 0;
            fill_cnt[k] = 0;
         end
         owed_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            cnt_results++;
            got.head_data   = rsp_tdata[31:0];
            got.head_level  = rsp_tdata[35:32];
            got.is_empty    = rsp_tdata[36];
            got.total_count = rsp_tdata[44:37];
            got.status      = status_type'(rsp_tdata[46:45]);
            if (owed_reports.size() == 0) begin
               $error("result item with no request waiting: 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = owed_reports.pop_front();
               check_field("head_data", want.head_data, got.head_data);
               check_field("head_level", ENTRY_W'(want.head_level), ENTRY_W'(got.head_level));
               check_field("is_empty", ENTRY_W'(want.is_empty), ENTRY_W'(got.is_empty));
               check_field("total_count", ENTRY_W'(want.total_count),
                           ENTRY_W'(got.total_count));
               check_field("status", ENTRY_W'(want.status), ENTRY_W'(got.status));
            end
         end
         if (req_tvalid && req_tready) begin
            cnt_requests++;
            owed_reports.push_back(apply_request(mode_type'(req_tuser), req_tdata[3:0],
                                                 req_tdata[10:4], req_tdata[42:11]));
         end
      end
      error_count     <= mismatches;
      pending         <= owed_reports.size();
      n_requests      <= cnt_requests;
      n_results       <= cnt_results;
      n_full_drops    <= cnt_full;
      n_range_drops   <= cnt_range;
      n_empty_removes <= cnt_empty;
      peak_total      <= cnt_peak;
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the multi-level FIFO priority queue with a short directed sequence
// (empty queue, bad levels, age band edges, a full level) and then with
// random phases that fill, drain or mix the levels, under random gaps on
// both streams. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import mfpq_pkg::*;

   localparam int NLEV         = LEVELS_DEF;
   localparam int RANDOM_ITEMS = 1800;
   localparam int IDLE_LIMIT   = 1000;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   bit                     gaps_on    = 1'b0;

   int error_count;
   int pending;
   int n_requests;
   int n_results;
   int n_full_drops;
   int n_range_drops;
   int n_empty_removes;
   int peak_total;

   always #1 clock = ~clock;

   multilevel_fifo_priority_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mfpq_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .pending         (pending),
      .n_requests      (n_requests),
      .n_results       (n_results),
      .n_full_drops    (n_full_drops),
      .n_range_drops   (n_range_drops),
      .n_empty_removes (n_empty_removes),
      .peak_total      (peak_total)
   );

   function automatic int pause_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_req(input mode_type op, input int lv, input int ag,
                           input logic [ENTRY_W-1:0] payload);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({payload, AGE_W'(ag), LEVEL_W'(lv)});
      do @(posedge clock); while (!req_tready);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pause_len()) @(posedge clock);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      @(posedge clock);
      forever begin
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pause_len()) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      phase_kind_type kind;
      mode_type       op;
      int span;
      int lv_lo;
      int lv_hi;
      int focus;
      int roll;
      int ins_pct;
      int rem_pct;
      int lv;
      int ag;
      int n;

      do @(posedge clock); while (reset);

      send_req(MODE_QUERY, 0, 0, '0);
      send_req(MODE_REMOVE, 0, 0, '1);
      send_req(MODE_INSERT, 15, 127, 32'hFFFF_FFFF);
      send_req(MODE_INSERT, 9, 0, 32'h1234_5678);
      send_req(MODE_INSERT_AGE, 0, 80, 32'hFFFF_FFFF);
      send_req(MODE_INSERT_AGE, 0, 127, 32'h0000_0000);
      for (int i = 0; i < 14; i++) send_req(MODE_INSERT, NLEV - 1, i, $urandom());
      send_req(MODE_INSERT, NLEV - 1, 0, 32'hDEAD_BEEF);
      send_req(MODE_INSERT_AGE, 0, 79, $urandom());
      send_req(MODE_INSERT_AGE, 0, 10, $urandom());
      send_req(MODE_INSERT_AGE, 0, 9, $urandom());
      send_req(MODE_INSERT_AGE, 0, 0, $urandom());
      send_req(MODE_REMOVE, 0, 0, '0);
      send_req(MODE_QUERY, 15, 127, '1);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         kind    = phase_kind_type'($urandom_range(0, 2));
         span    = $urandom_range(30, 120);
         lv_lo   = $urandom_range(0, NLEV - 1);
         lv_hi   = lv_lo + $urandom_range(0, 2);
         if (lv_hi > NLEV - 1) lv_hi = NLEV - 1;
         gaps_on = ($urandom_range(0, 3) != 0);
         case (kind)
            PH_FILL:  begin ins_pct = 80; rem_pct = 10; end
            PH_DRAIN: begin ins_pct = 15; rem_pct = 75; end
            default:  begin ins_pct = 45; rem_pct = 35; end
         endcase
         repeat (span) begin
            roll  = $urandom_range(0, 99);
            focus = $urandom_range(lv_lo, lv_hi);
            lv    = $urandom_range(0, 15);
            ag    = $urandom_range(0, 127);
            if (roll < ins_pct) begin
               op = ($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_INSERT_AGE;
               if (kind != PH_MIX) begin
                  lv = focus;
                  ag = (focus < BANDS) ? focus * 10 + $urandom_range(0, 9)
                                       : $urandom_range(BANDS * 10, 127);
               end
            end else if (roll < ins_pct + rem_pct) begin
               op = MODE_REMOVE;
            end else if ($urandom_range(0, 1) == 0) begin
               op = MODE_QUERY;
            end else begin
               op = MODE_INSERT;
               lv = $urandom_range(NLEV, 15);
            end
            send_req(op, lv, ag, $urandom());
            n++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d requests and %0d results; peak occupancy %0d entries.",
               n_requests, n_results, peak_total);
      $display("Drops: %0d on a full level, %0d on a bad level; %0d removes on empty.",
               n_full_drops, n_range_drops, n_empty_removes);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/mfpq_pkg.sv
rtl/core/mfpq_ram.sv
rtl/core/mfpq_core.sv
rtl/core/multilevel_fifo_priority_queue.sv
tb/sv/mfpq_checker.sv
tb/sv/testbench.sv
